@@ rtl/asme_pkg.sv @@
package asme_pkg;

    // opcodes
    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_MULT   = 5'd2;
    localparam logic [4:0] OP_DIV    = 5'd3;
    localparam logic [4:0] OP_LOAD   = 5'd4;
    localparam logic [4:0] OP_STORE  = 5'd5;
    localparam logic [4:0] OP_COPY   = 5'd6;
    localparam logic [4:0] OP_READ   = 5'd7;
    localparam logic [4:0] OP_WRITE  = 5'd8;
    localparam logic [4:0] OP_STOP   = 5'd9;
    localparam logic [4:0] OP_NOOP   = 5'd10;
    localparam logic [4:0] OP_BR     = 5'd11;
    localparam logic [4:0] OP_BRNEG  = 5'd12;
    localparam logic [4:0] OP_BRZNEG = 5'd13;
    localparam logic [4:0] OP_BRPOS  = 5'd14;
    localparam logic [4:0] OP_BRZPOS = 5'd15;
    localparam logic [4:0] OP_BRZERO = 5'd16;
    localparam logic [4:0] OP_PUSH   = 5'd17;
    localparam logic [4:0] OP_POP    = 5'd18;
    localparam logic [4:0] OP_STACKW = 5'd19;
    localparam logic [4:0] OP_STACKR = 5'd20;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_INDEX     = 3'd3;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_VRD,
        S_EXEC,
        S_ITER,
        S_SRD
    } t_state;

    typedef struct packed {
        logic start;
        logic div;
    } t_iter_req;

endpackage

@@ rtl/asme_ram.sv @@
module asme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/asme_muldiv.sv @@
module asme_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  asme_pkg::t_iter_req  i_req,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output logic                 o_done,
    output logic [31:0]          o_result
);

    logic        r_busy;
    logic        r_done;
    logic        r_div;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_p;

    logic [32:0] w_rem_sh;
    logic [32:0] w_opa;
    logic [32:0] w_opb;
    logic [33:0] w_sum;

    // shared adder: shift-add for multiply, trial subtract for divide
    always_comb begin
        w_rem_sh = {r_p, r_y[31]};
        if (r_div) begin
            w_opa = w_rem_sh;
            w_opb = ~{1'b0, r_x};
        end else begin
            w_opa = {1'b0, r_p};
            w_opb = r_y[0] ? {1'b0, r_x} : 33'd0;
        end
        w_sum = {1'b0, w_opa} + {1'b0, w_opb} + 34'(r_div);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands: load magnitudes for divide, raw values for multiply
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.div;
            r_neg <= i_a[31] ^ i_b[31];
            r_p   <= 32'd0;
            if (i_req.div) begin
                r_y <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_x <= i_b[31] ? (32'd0 - i_b) : i_b;
            end else begin
                r_y <= i_b;
                r_x <= i_a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_p <= w_sum[33] ? w_sum[31:0] : w_rem_sh[31:0];
                r_y <= {r_y[30:0], w_sum[33]};
            end else begin
                r_p <= w_sum[31:0];
                r_x <= {r_x[30:0], 1'b0};
                r_y <= {1'b0, r_y[31:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (32'd0 - r_y) : r_y) : r_p;

endmodule

@@ rtl/accumulator_stack_machine_execute_core.sv @@
// Execute core of a 32-bit accumulator machine with a variable store and a
// data stack. One decoded instruction comes in as a word on the input
// channel (i_valid / o_ready); one result word leaves on the output channel
// (o_valid / i_ready) for every instruction.
// Most instructions pass through a variable read and an execute state; STACKR
// adds a stack read state, and MULT and DIV run one bit per cycle on the shared
// multiply/divide unit. One instruction is in flight at a time; the next word is taken once
// the previous result has been taken from the output register.
// Halted instructions (after STOP or an error) return in the next cycle.
// After reset every stack memory entry is cleared, one entry per cycle,
// with o_ready low. Accumulator, ip, stack count and halt flag reset
// to zero. Variables hold no defined value until written.
// If the receiver stalls, the result holds in the output register and no
// new word is accepted. Depth parameters are to be powers of two; the block itself does not enforce this.
module accumulator_stack_machine_execute_core #(
    parameter int STACK_DEPTH = 1024,
    parameter int VAR_DEPTH   = 256,
    parameter int PROG_DEPTH  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_mode,
    input  logic [7:0]  i_var_a,
    input  logic [7:0]  i_var_b,
    input  logic [9:0]  i_branch_target,
    input  logic signed [31:0] i_read_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_next_ip,
    output logic signed [31:0] o_acc_value,
    output logic        o_write_valid,
    output logic [7:0]  o_write_index,
    output logic signed [31:0] o_write_value,
    output logic        o_halted,
    output logic [2:0]  o_error_code
);

    localparam int VAW = $clog2(VAR_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    asme_pkg::t_state r_state, n_state;

    logic [31:0]    r_acc, n_acc;
    logic [PAW-1:0] r_ip, n_ip;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_halt, n_halt;
    logic [SAW-1:0] r_clr;
    logic [4:0]     r_mode;
    logic [VAW-1:0] r_ia;
    logic [PAW-1:0] r_target;
    logic [31:0]    r_rval;

    logic [9:0]  r_o_nip, n_o_nip;
    logic [31:0] r_o_acc, n_o_acc;
    logic        r_o_wv, n_o_wv;
    logic [7:0]  r_o_widx, n_o_widx;
    logic [31:0] r_o_wval, n_o_wval;
    logic        r_o_halt, n_o_halt;
    logic [2:0]  r_o_err, n_o_err;
    logic        r_o_valid, n_o_valid;

    logic           w_accept;
    logic           w_fin;
    logic           w_taken;
    logic [2:0]     w_err;
    logic [PAW-1:0] w_ipinc;
    logic           w_slot_ok;
    logic [SAW-1:0] w_slot;

    logic           w_var_we, w_var_re;
    logic [VAW-1:0] w_var_waddr, w_var_raddr;
    logic [31:0]    w_var_wdata, w_var_rdata;
    logic           w_stk_we, w_stk_re;
    logic [SAW-1:0] w_stk_waddr;
    logic [31:0]    w_stk_wdata, w_stk_rdata;

    asme_pkg::t_iter_req w_iter_req;
    logic                w_iter_done;
    logic [31:0]         w_iter_result;

    assign o_ready  = (r_state == asme_pkg::S_IDLE) && !r_o_valid;
    assign w_accept = i_valid && o_ready;
    assign w_ipinc  = (r_ip == PAW'(PROG_DEPTH - 1)) ? '0 : r_ip + PAW'(1);

    // stack offset from the top, taken from the variable just read
    assign w_slot_ok = !w_var_rdata[31] && (w_var_rdata < 32'(r_cnt));
    assign w_slot    = SAW'(r_cnt - CW'(1) - CW'(w_var_rdata));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            asme_pkg::S_CLEAR: begin
                if (r_clr == SAW'(STACK_DEPTH - 1)) n_state = asme_pkg::S_IDLE;
            end
            asme_pkg::S_IDLE: begin
                if (w_accept && !r_halt) n_state = asme_pkg::S_VRD;
            end
            asme_pkg::S_VRD: n_state = asme_pkg::S_EXEC;
            asme_pkg::S_EXEC: begin
                n_state = asme_pkg::S_IDLE;
                case (r_mode)
                    asme_pkg::OP_MULT: n_state = asme_pkg::S_ITER;
                    asme_pkg::OP_DIV: begin
                        if (w_var_rdata != 32'd0) n_state = asme_pkg::S_ITER;
                    end
                    asme_pkg::OP_STACKR: begin
                        if (w_slot_ok) n_state = asme_pkg::S_SRD;
                    end
                    default: n_state = asme_pkg::S_IDLE;
                endcase
            end
            asme_pkg::S_ITER: begin
                if (w_iter_done) n_state = asme_pkg::S_IDLE;
            end
            asme_pkg::S_SRD: n_state = asme_pkg::S_IDLE;
            default: n_state = asme_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_acc      = r_acc;
        n_ip       = r_ip;
        n_cnt      = r_cnt;
        n_halt     = r_halt;
        w_fin      = 1'b0;
        w_taken    = 1'b0;
        w_err      = asme_pkg::ERR_NONE;
        n_o_wv     = 1'b0;
        n_o_widx   = 8'd0;
        n_o_wval   = 32'd0;
        w_var_we   = 1'b0;
        w_var_waddr = r_ia;
        w_var_wdata = r_acc;
        w_var_re   = 1'b0;
        w_var_raddr = (i_mode == asme_pkg::OP_COPY) ? VAW'(i_var_b) : VAW'(i_var_a);
        w_stk_we   = 1'b0;
        w_stk_waddr = w_slot;
        w_stk_wdata = r_acc;
        w_stk_re   = 1'b0;
        w_iter_req = '0;
        case (r_state)
            asme_pkg::S_CLEAR: begin
                w_stk_we    = 1'b1;
                w_stk_waddr = r_clr;
                w_stk_wdata = 32'd0;
            end
            asme_pkg::S_IDLE: begin
                w_var_re = w_accept && !r_halt;
                w_fin    = w_accept && r_halt;
            end
            asme_pkg::S_EXEC: begin
                w_fin = 1'b1;
                case (r_mode)
                    asme_pkg::OP_ADD:  n_acc = r_acc + w_var_rdata;
                    asme_pkg::OP_SUB:  n_acc = r_acc - w_var_rdata;
                    asme_pkg::OP_MULT: begin
                        w_fin          = 1'b0;
                        w_iter_req.start = 1'b1;
                    end
                    asme_pkg::OP_DIV: begin
                        if (w_var_rdata == 32'd0) begin
                            w_err = asme_pkg::ERR_DIV_ZERO;
                        end else begin
                            w_fin            = 1'b0;
                            w_iter_req.start = 1'b1;
                            w_iter_req.div   = 1'b1;
                        end
                    end
                    asme_pkg::OP_LOAD:  n_acc = w_var_rdata;
                    asme_pkg::OP_STORE: w_var_we = 1'b1;
                    asme_pkg::OP_COPY: begin
                        w_var_we    = 1'b1;
                        w_var_wdata = w_var_rdata;
                    end
                    asme_pkg::OP_READ: begin
                        w_var_we    = 1'b1;
                        w_var_wdata = r_rval;
                    end
                    asme_pkg::OP_WRITE: begin
                        n_o_wv   = 1'b1;
                        n_o_widx = 8'(r_ia);
                        n_o_wval = w_var_rdata;
                    end
                    asme_pkg::OP_STOP:   n_halt  = 1'b1;
                    asme_pkg::OP_BR:     w_taken = 1'b1;
                    asme_pkg::OP_BRNEG:  w_taken = r_acc[31];
                    asme_pkg::OP_BRZNEG: w_taken = r_acc[31] || (r_acc == 32'd0);
                    asme_pkg::OP_BRPOS:  w_taken = !r_acc[31] && (r_acc != 32'd0);
                    asme_pkg::OP_BRZPOS: w_taken = !r_acc[31];
                    asme_pkg::OP_BRZERO: w_taken = (r_acc == 32'd0);
                    asme_pkg::OP_PUSH: begin
                        if (r_cnt == CW'(STACK_DEPTH)) w_err = asme_pkg::ERR_OVERFLOW;
                        else n_cnt = r_cnt + CW'(1);
                    end
                    asme_pkg::OP_POP: begin
                        if (r_cnt == '0) w_err = asme_pkg::ERR_UNDERFLOW;
                        else n_cnt = r_cnt - CW'(1);
                    end
                    asme_pkg::OP_STACKW: begin
                        if (w_slot_ok) w_stk_we = 1'b1;
                        else w_err = asme_pkg::ERR_INDEX;
                    end
                    asme_pkg::OP_STACKR: begin
                        if (w_slot_ok) begin
                            w_fin    = 1'b0;
                            w_stk_re = 1'b1;
                        end else begin
                            w_err = asme_pkg::ERR_INDEX;
                        end
                    end
                    default: n_acc = r_acc;
                endcase
                if (w_err != asme_pkg::ERR_NONE) n_halt = 1'b1;
                if (n_halt) n_ip = r_ip;
                else if (w_taken) n_ip = r_target;
                else n_ip = w_ipinc;
            end
            // ip already advanced in the execute cycle
            asme_pkg::S_ITER: begin
                if (w_iter_done) begin
                    w_fin = 1'b1;
                    n_acc = w_iter_result;
                end
            end
            asme_pkg::S_SRD: begin
                w_fin = 1'b1;
                n_acc = w_stk_rdata;
            end
            default: w_fin = 1'b0;
        endcase
    end

    // result word: load on finish, drop once taken
    always_comb begin
        n_o_nip   = 10'(n_ip);
        n_o_acc   = n_acc;
        n_o_halt  = n_halt;
        n_o_err   = w_err;
        n_o_valid = r_o_valid;
        if (w_fin) n_o_valid = 1'b1;
        else if (r_o_valid && i_ready) n_o_valid = 1'b0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= asme_pkg::S_CLEAR;
            r_acc     <= 32'd0;
            r_ip      <= '0;
            r_cnt     <= '0;
            r_halt    <= 1'b0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_ip      <= n_ip;
            r_cnt     <= n_cnt;
            r_halt    <= n_halt;
            r_o_valid <= n_o_valid;
            if (r_state == asme_pkg::S_CLEAR) r_clr <= r_clr + SAW'(1);
        end
    end

    // hold the instruction word and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_ia     <= VAW'(i_var_a);
            r_target <= PAW'(i_branch_target);
            r_rval   <= i_read_value;
        end
        if (w_fin) begin
            r_o_nip  <= n_o_nip;
            r_o_acc  <= n_o_acc;
            r_o_wv   <= n_o_wv;
            r_o_widx <= n_o_widx;
            r_o_wval <= n_o_wval;
            r_o_halt <= n_o_halt;
            r_o_err  <= n_o_err;
        end
    end

    asme_ram #(.WIDTH(32), .DEPTH(VAR_DEPTH)) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (w_var_we),
        .i_waddr (w_var_waddr),
        .i_wdata (w_var_wdata),
        .i_re    (w_var_re),
        .i_raddr (w_var_raddr),
        .o_rdata (w_var_rdata)
    );

    asme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_slot),
        .o_rdata (w_stk_rdata)
    );

    asme_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_iter_req),
        .i_a      (r_acc),
        .i_b      (w_var_rdata),
        .o_done   (w_iter_done),
        .o_result (w_iter_result)
    );

    assign o_valid       = r_o_valid;
    assign o_next_ip     = r_o_nip;
    assign o_acc_value   = r_o_acc;
    assign o_write_valid = r_o_wv;
    assign o_write_index = r_o_widx;
    assign o_write_value = r_o_wval;
    assign o_halted      = r_o_halt;
    assign o_error_code  = r_o_err;

    // an error always reports a halted machine
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_code != asme_pkg::ERR_NONE) |-> o_halted)
        else $error("error reported without halt");

    // once halted, stay halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // stack count stays within the stack depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count out of range");

    // a WRITE never raises an error
    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_valid |-> (o_error_code == asme_pkg::ERR_NONE) && !o_halted)
        else $error("write word carries error");

endmodule

@@ test/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 1024;
    localparam int VAR_DEPTH   = 256;
    localparam int PROG_DEPTH  = 1024;
    localparam int RAND_WORDS  = 500;
    localparam int IDLE_PCT    = 26;
    localparam int STALL_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 60;

    // one instruction word and one result word
    typedef struct packed {
        logic [4:0]  mode;
        logic [7:0]  var_a;
        logic [7:0]  var_b;
        logic [9:0]  target;
        logic [31:0] rval;
    } t_instr;

    typedef struct packed {
        logic [9:0]  next_ip;
        logic [31:0] acc;
        logic        wr_valid;
        logic [7:0]  wr_index;
        logic [31:0] wr_value;
        logic        halted;
        logic [2:0]  err;
    } t_result;

    // machine state: copy PLAN tracks the stimulus, copy CHK tracks the checker
    localparam int PLAN = 0;
    localparam int CHK  = 1;
    logic [31:0] acc_m   [2];
    logic [9:0]  ip_m    [2];
    logic [31:0] vars_m  [2][VAR_DEPTH];
    logic [31:0] stk_m   [2][STACK_DEPTH];
    int          count_m [2];
    logic        halt_m  [2];

    int      written_q [$];
    logic    written   [VAR_DEPTH];
    t_instr  pending_q [$];
    t_result results_due_q [$];
    int      error_count;
    int      cycle_count;
    int      stall_count;

    logic        i_clk, i_rst_n, i_valid, i_ready;
    logic [4:0]  i_mode;
    logic [7:0]  i_var_a, i_var_b;
    logic [9:0]  i_branch_target;
    logic signed [31:0] i_read_value;
    logic        o_ready, o_valid, o_write_valid, o_halted;
    logic [9:0]  o_next_ip;
    logic signed [31:0] o_acc_value, o_write_value;
    logic [7:0]  o_write_index;
    logic [2:0]  o_error_code;
    logic        word_taken;

    accumulator_stack_machine_execute_core dut (.*);

    // signed divide truncating toward zero, min / -1 wraps
    function automatic logic [31:0] div_trunc(logic [31:0] num, logic [31:0] den);
        logic [31:0] un, ud, q;
        un = num[31] ? -num : num;
        ud = den[31] ? -den : den;
        q  = un / ud;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    // execute one instruction on state copy c
    function automatic t_result exec_instr(int c, t_instr it);
        t_result r;
        logic [31:0] va, vb;
        logic signed [31:0] sacc;
        longint n, slot;
        logic taken;
        r = '0;
        taken = 1'b0;
        if (halt_m[c]) begin
            r.next_ip = ip_m[c];
        end else begin
            va = vars_m[c][it.var_a];
            vb = vars_m[c][it.var_b];
            sacc = acc_m[c];
            n = longint'($signed(va));
            slot = (n < 0 || n >= count_m[c]) ? -1 : count_m[c] - 1 - n;
            case (it.mode)
                asme_pkg::OP_ADD:  acc_m[c] = acc_m[c] + va;
                asme_pkg::OP_SUB:  acc_m[c] = acc_m[c] - va;
                asme_pkg::OP_MULT: acc_m[c] = acc_m[c] * va;
                asme_pkg::OP_DIV: begin
                    if (va == 0) r.err = asme_pkg::ERR_DIV_ZERO;
                    else acc_m[c] = div_trunc(acc_m[c], va);
                end
                asme_pkg::OP_LOAD:  acc_m[c] = va;
                asme_pkg::OP_STORE: vars_m[c][it.var_a] = acc_m[c];
                asme_pkg::OP_COPY:  vars_m[c][it.var_a] = vb;
                asme_pkg::OP_READ:  vars_m[c][it.var_a] = it.rval;
                asme_pkg::OP_WRITE: begin
                    r.wr_valid = 1'b1;
                    r.wr_index = it.var_a;
                    r.wr_value = va;
                end
                asme_pkg::OP_STOP:   halt_m[c] = 1'b1;
                asme_pkg::OP_BR:     taken = 1'b1;
                asme_pkg::OP_BRNEG:  taken = sacc < 0;
                asme_pkg::OP_BRZNEG: taken = sacc <= 0;
                asme_pkg::OP_BRPOS:  taken = sacc > 0;
                asme_pkg::OP_BRZPOS: taken = sacc >= 0;
                asme_pkg::OP_BRZERO: taken = sacc == 0;
                asme_pkg::OP_PUSH: begin
                    if (count_m[c] >= STACK_DEPTH) r.err = asme_pkg::ERR_OVERFLOW;
                    else count_m[c]++;
                end
                asme_pkg::OP_POP: begin
                    if (count_m[c] == 0) r.err = asme_pkg::ERR_UNDERFLOW;
                    else count_m[c]--;
                end
                asme_pkg::OP_STACKW: begin
                    if (slot < 0) r.err = asme_pkg::ERR_INDEX;
                    else stk_m[c][slot] = acc_m[c];
                end
                asme_pkg::OP_STACKR: begin
                    if (slot < 0) r.err = asme_pkg::ERR_INDEX;
                    else acc_m[c] = stk_m[c][slot];
                end
                default: ;
            endcase
            if (r.err != asme_pkg::ERR_NONE) halt_m[c] = 1'b1;
            if (!halt_m[c]) ip_m[c] = taken ? it.target : ip_m[c] + 10'd1;
            r.next_ip = ip_m[c];
        end
        r.acc = acc_m[c];
        r.halted = halt_m[c];
        return r;
    endfunction

    // queue a word and advance the planning copy
    task automatic add_word(logic [4:0] mode, int a, int b, logic [31:0] rval);
        t_instr it;
        it.mode = mode;
        it.var_a = a[7:0];
        it.var_b = b[7:0];
        it.target = 10'($urandom_range(0, PROG_DEPTH - 1));
        it.rval = rval;
        if (!halt_m[PLAN] && (mode == asme_pkg::OP_STORE || mode == asme_pkg::OP_COPY
                || mode == asme_pkg::OP_READ) && !written[a]) begin
            written[a] = 1'b1;
            written_q.push_back(a);
        end
        void'(exec_instr(PLAN, it));
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_written();
        return written_q[$urandom_range(0, written_q.size() - 1)];
    endfunction

    // one random step (sometimes an unused opcode), with a setup READ where needed
    task automatic add_random_word();
        int a;
        logic [4:0] op;
        if ($urandom_range(0, 99) < 5) begin
            add_word(5'($urandom_range(asme_pkg::OP_STACKR + 1, 31)), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom());
            return;
        end
        op = 5'($urandom_range(asme_pkg::OP_ADD, asme_pkg::OP_STACKR));
        if (written_q.size() == 0 || $urandom_range(0, 99) < 10) op = asme_pkg::OP_READ;
        if (op == asme_pkg::OP_STOP) op = asme_pkg::OP_NOOP;
        if (op == asme_pkg::OP_POP && count_m[PLAN] == 0) op = asme_pkg::OP_PUSH;
        if (op == asme_pkg::OP_PUSH && count_m[PLAN] == STACK_DEPTH) op = asme_pkg::OP_POP;
        if ((op == asme_pkg::OP_STACKW || op == asme_pkg::OP_STACKR) && count_m[PLAN] == 0)
            op = asme_pkg::OP_PUSH;
        case (op)
            asme_pkg::OP_READ, asme_pkg::OP_STORE:
                add_word(op, $urandom_range(0, 255), $urandom_range(0, 255), rand_value());
            asme_pkg::OP_COPY:
                add_word(op, $urandom_range(0, 255), pick_written(), $urandom());
            asme_pkg::OP_DIV: begin
                a = pick_written();
                if (vars_m[PLAN][a] == 0)
                    add_word(asme_pkg::OP_READ, a, 0, $urandom() | 32'd1);
                add_word(op, a, $urandom_range(0, 255), $urandom());
            end
            asme_pkg::OP_STACKW, asme_pkg::OP_STACKR: begin
                a = $urandom_range(0, 255);
                add_word(asme_pkg::OP_READ, a, 0, $urandom_range(0, count_m[PLAN] - 1));
                add_word(op, a, $urandom_range(0, 255), $urandom());
            end
            asme_pkg::OP_ADD, asme_pkg::OP_SUB, asme_pkg::OP_MULT, asme_pkg::OP_LOAD,
            asme_pkg::OP_WRITE:
                add_word(op, pick_written(), $urandom_range(0, 255), $urandom());
            default:
                add_word(op, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        endcase
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("mismatch %s: expected %h got %h at cycle %0d", what, exp_v, got_v,
                 cycle_count);
        error_count++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // count cycles and guard against a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic logic idle_now();
        if (cycle_count > 3000 && cycle_count < 4500) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // drive words at the falling edge
    always @(negedge i_clk) begin
        i_ready <= i_rst_n && !idle_now();
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (pending_q.size() != 0 && !idle_now()) begin
                i_valid         <= 1'b1;
                i_mode          <= pending_q[0].mode;
                i_var_a         <= pending_q[0].var_a;
                i_var_b         <= pending_q[0].var_b;
                i_branch_target <= pending_q[0].target;
                i_read_value    <= pending_q[0].rval;
                pending_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // check results and predict at the rising edge
    always @(posedge i_clk) begin
        t_result got, exp_r;
        t_instr it;
        word_taken <= i_valid && o_ready;
        if (o_valid && i_ready) begin
            got = {o_next_ip, o_acc_value, o_write_valid, o_write_index, o_write_value,
                   o_halted, o_error_code};
            if (results_due_q.size() == 0) begin
                report("unexpected word", 32'd0, 32'd0);
            end else begin
                exp_r = results_due_q.pop_front();
                if (got.next_ip != exp_r.next_ip)
                    report("next_ip", 32'(exp_r.next_ip), 32'(got.next_ip));
                if (got.acc != exp_r.acc) report("acc_value", exp_r.acc, got.acc);
                if (got.wr_valid != exp_r.wr_valid)
                    report("write_valid", 32'(exp_r.wr_valid), 32'(got.wr_valid));
                if (got.wr_index != exp_r.wr_index)
                    report("write_index", 32'(exp_r.wr_index), 32'(got.wr_index));
                if (got.wr_value != exp_r.wr_value)
                    report("write_value", exp_r.wr_value, got.wr_value);
                if (got.halted != exp_r.halted)
                    report("halted", 32'(exp_r.halted), 32'(got.halted));
                if (got.err != exp_r.err)
                    report("error_code", 32'(exp_r.err), 32'(got.err));
            end
        end
        if (i_valid && o_ready) begin
            it = {i_mode, i_var_a, i_var_b, i_branch_target, i_read_value};
            results_due_q.push_back(exec_instr(CHK, it));
        end
    end

    // build the stimulus, run, and wait for the drain
    initial begin
        int a;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode = asme_pkg::OP_NOOP;
        i_var_a = '0;
        i_var_b = '0;
        i_branch_target = '0;
        i_read_value = '0;
        word_taken = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stall_count = 0;
        for (int c = 0; c < 2; c++) begin
            acc_m[c] = '0;
            ip_m[c] = '0;
            count_m[c] = 0;
            halt_m[c] = 1'b0;
            for (int i = 0; i < VAR_DEPTH; i++) vars_m[c][i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++) stk_m[c][i] = '0;
        end
        for (int i = 0; i < VAR_DEPTH; i++) written[i] = 1'b0;

        // directed: field extremes, wraps, every opcode but STOP
        add_word(asme_pkg::OP_READ, 0, 0, 32'd1);
        add_word(asme_pkg::OP_READ, 255, 0, 32'h8000_0000);
        add_word(asme_pkg::OP_READ, 1, 0, 32'hffff_ffff);
        add_word(asme_pkg::OP_READ, 2, 0, 32'h7fff_ffff);
        add_word(asme_pkg::OP_READ, 3, 0, 32'd0);
        add_word(asme_pkg::OP_BRZERO, 0, 0, 0);
        add_word(asme_pkg::OP_LOAD, 255, 0, 0);
        add_word(asme_pkg::OP_BRNEG, 0, 0, 0);
        add_word(asme_pkg::OP_DIV, 1, 0, 0);
        add_word(asme_pkg::OP_SUB, 0, 0, 0);
        add_word(asme_pkg::OP_BRPOS, 0, 0, 0);
        add_word(asme_pkg::OP_ADD, 2, 0, 0);
        add_word(asme_pkg::OP_MULT, 2, 0, 0);
        add_word(asme_pkg::OP_BRZPOS, 0, 0, 0);
        add_word(asme_pkg::OP_COPY, 4, 255, 0);
        add_word(asme_pkg::OP_STORE, 5, 0, 0);
        add_word(asme_pkg::OP_WRITE, 4, 0, 0);
        add_word(asme_pkg::OP_BRZNEG, 0, 0, 0);
        add_word(asme_pkg::OP_BR, 0, 0, 0);
        add_word(asme_pkg::OP_NOOP, 255, 255, 32'hffff_ffff);
        add_word(5'd31, 0, 0, 0);
        add_word(asme_pkg::OP_PUSH, 0, 0, 0);
        add_word(asme_pkg::OP_STACKW, 3, 0, 0);
        add_word(asme_pkg::OP_STACKR, 3, 0, 0);
        add_word(asme_pkg::OP_POP, 0, 0, 0);

        for (int i = 0; i < RAND_WORDS; i++) add_random_word();

        // finish with one halting case, then words to a halted machine
        case ($urandom_range(0, 3))
            1: begin
                add_word(asme_pkg::OP_READ, 7, 0, 32'd0);
                add_word(asme_pkg::OP_DIV, 7, 0, 0);
            end
            2: begin
                while (count_m[PLAN] > 0) add_word(asme_pkg::OP_POP, 0, 0, 0);
                add_word(asme_pkg::OP_POP, 0, 0, 0);
            end
            3: begin
                a = $urandom_range(0, 1) ? count_m[PLAN] : -1 - $urandom_range(0, 9);
                add_word(asme_pkg::OP_READ, 9, 0, a);
                add_word($urandom_range(0, 1) ? asme_pkg::OP_STACKR : asme_pkg::OP_STACKW,
                         9, 0, 0);
            end
            default: add_word(asme_pkg::OP_STOP, 0, 0, 0);
        endcase
        for (int i = 0; i < 6; i++)
            add_word(5'($urandom_range(asme_pkg::OP_READ, asme_pkg::OP_BRZERO)),
                     $urandom_range(0, 255), 0, $urandom());

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid || results_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
